>>> hw/rtl/rds_pkg.sv
// Package of shared types, constants and register indexes for the rate display stabiliser.
`default_nettype none
package rds_pkg;

    localparam int unsigned TENTHS_UNIT = 100000;
    localparam int unsigned WHOLE_UNIT  = 1000000;
    localparam int unsigned SEED_SPLIT  = 1000000;
    localparam int unsigned WHOLE_CAP   = 99000000;

    localparam logic [3:0]  DOT_SYMBOL  = 4'd10;
    localparam logic [6:0]  MAX_TENTHS  = 7'd9;
    localparam logic [6:0]  MIN_WHOLE   = 7'd1;
    localparam logic [6:0]  MAX_WHOLE   = 7'd99;

    localparam logic [48:0] HALF_TENTHS = 49'd3276800000;
    localparam logic [48:0] HALF_WHOLE  = 49'd32768000000;
    localparam logic [27:0] RECIP_WHOLE = 28'd140737489;
    localparam logic [24:0] BAND_TENTHS = 25'd10000;
    localparam logic [24:0] BAND_WHOLE  = 25'd100000;

    localparam logic [2:0] REG_EMA_ALPHA      = 3'd0;
    localparam logic [2:0] REG_MODE_UP_RATE   = 3'd1;
    localparam logic [2:0] REG_MODE_DOWN_RATE = 3'd2;
    localparam logic [2:0] REG_BAND_TENTHS    = 3'd3;
    localparam logic [2:0] REG_HOLD_LENGTH    = 3'd4;
    localparam logic [2:0] REG_COMMIT_LENGTH  = 3'd5;

    localparam logic signed [1:0] DIR_UP   = 2'sb01;
    localparam logic signed [1:0] DIR_DOWN = 2'sb11;
    localparam logic signed [1:0] DIR_NONE = 2'sb00;

    typedef struct packed {
        logic [15:0] ema_alpha;
        logic [31:0] mode_up_rate;
        logic [31:0] mode_down_rate;
        logic [7:0]  band_tenths;
        logic [7:0]  hold_length;
        logic [7:0]  commit_length;
    } t_cfg;

    typedef struct packed {
        logic        seed;
        logic        seed_tenths;
        logic        up_hit;
        logic        down_hit;
        logic [3:0]  round_tenths;
        logic [6:0]  round_whole;
        logic [47:0] avg;
    } t_filtered;

    typedef struct packed {
        logic              tenths_mode;
        logic [6:0]        value;
        logic signed [1:0] direction;
    } t_shown;

endpackage
`default_nettype wire

>>> hw/rtl/rds_ema.sv
// Moving average stage: seeds from the first sample, then updates the Q32.16 average.
`default_nettype none
module rds_ema (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_load,
    input  wire logic [31:0] i_rate,
    input  wire logic [15:0] i_alpha,
    output logic      [47:0] o_avg,
    output logic             o_seed
);
    import rds_pkg::*;

    logic        r_seeded;
    logic        r_seed;
    logic [47:0] r_avg;
    logic [47:0] n_avg;
    logic [47:0] x;
    logic        ge;
    logic [47:0] diff;
    logic [39:0] pp_lo;
    logic [39:0] pp_hi;
    logic [63:0] prod;
    logic [47:0] step;

    always_comb begin
        x     = {i_rate, 16'b0};
        ge    = x >= r_avg;
        diff  = ge ? (x - r_avg) : (r_avg - x);
        pp_lo = 40'(diff[23:0]) * 40'(i_alpha);
        pp_hi = 40'(diff[47:24]) * 40'(i_alpha);
        prod  = {pp_hi, 24'b0} + 64'(pp_lo);
        step  = prod[63:16];
        n_avg = ge ? (r_avg + step) : (r_avg - step);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seeded <= 1'b0;
            r_seed   <= 1'b0;
            r_avg    <= '0;
        end else if (i_load) begin
            r_seeded <= 1'b1;
            r_seed   <= !r_seeded;
            r_avg    <= r_seeded ? n_avg : x;
        end
    end

    assign o_avg  = r_avg;
    assign o_seed = r_seed;

endmodule
`default_nettype wire

>>> hw/rtl/rds_track.sv
// Display decision state: mode choice, hold counter, hysteresis band and candidate commit.
`default_nettype none
module rds_track (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_load,
    input  wire rds_pkg::t_filtered   i_item,
    input  wire rds_pkg::t_cfg        i_cfg,
    output rds_pkg::t_shown           o_shown
);
    import rds_pkg::*;

    logic              r_tenths;
    logic [6:0]        r_value;
    logic signed [1:0] r_dir;
    logic [7:0]        r_hold;
    logic              r_pvalid;
    logic              r_ptenths;
    logic [6:0]        r_pvalue;
    logic [7:0]        r_pcount;

    logic              n_tenths;
    logic [6:0]        n_value;
    logic signed [1:0] n_dir;
    logic [7:0]        n_hold;
    logic              n_pvalid;
    logic              n_ptenths;
    logic [6:0]        n_pvalue;
    logic [7:0]        n_pcount;

    logic              next_mode;
    logic              mode_flip;
    logic [26:0]       centre;
    logic [47:0]       centre_q;
    logic [47:0]       offset;
    logic [24:0]       thr;
    logic              far;
    logic [6:0]        cand;
    logic              match;
    logic [9:0]        old_rank;
    logic [9:0]        new_rank;

    always_comb begin
        n_tenths  = r_tenths;
        n_value   = r_value;
        n_dir     = r_dir;
        n_hold    = r_hold;
        n_pvalid  = r_pvalid;
        n_ptenths = r_ptenths;
        n_pvalue  = r_pvalue;
        n_pcount  = r_pcount;

        if (r_tenths) begin
            next_mode = !i_item.up_hit;
        end else begin
            next_mode = i_item.down_hit;
        end
        mode_flip = next_mode != r_tenths;
        centre   = next_mode ? (27'(r_value) * 27'(TENTHS_UNIT))
                             : (27'(r_value) * 27'(WHOLE_UNIT));
        centre_q = {5'b0, centre, 16'b0};
        offset   = (i_item.avg >= centre_q) ? (i_item.avg - centre_q)
                                            : (centre_q - i_item.avg);
        thr      = next_mode ? (25'(i_cfg.band_tenths) * BAND_TENTHS)
                             : (25'(i_cfg.band_tenths) * BAND_WHOLE);
        far      = offset[47:16] >= 32'(thr);
        cand     = next_mode ? 7'(i_item.round_tenths) : i_item.round_whole;
        match    = r_pvalid && (r_ptenths == next_mode) && (r_pvalue == cand);
        old_rank = r_tenths ? 10'(r_value) : (10'(r_value) * 10'd10);
        new_rank = next_mode ? 10'(cand) : (10'(cand) * 10'd10);

        if (i_item.seed) begin
            n_tenths = i_item.seed_tenths;
            n_value  = i_item.seed_tenths ? 7'(i_item.round_tenths) : i_item.round_whole;
        end else if (r_hold != 8'd0) begin
            n_hold = r_hold - 8'd1;
        end else if (far || mode_flip) begin
            if ((cand != r_value) || mode_flip) begin
                n_pvalid  = 1'b1;
                n_ptenths = next_mode;
                n_pvalue  = cand;
                if (match) begin
                    n_pcount = (r_pcount == 8'hFF) ? r_pcount : (r_pcount + 8'd1);
                end else begin
                    n_pcount = 8'd1;
                end
                if (n_pcount >= i_cfg.commit_length) begin
                    if (new_rank > old_rank) begin
                        n_dir = DIR_UP;
                    end else if (new_rank < old_rank) begin
                        n_dir = DIR_DOWN;
                    end else begin
                        n_dir = DIR_NONE;
                    end
                    n_tenths = next_mode;
                    n_value  = cand;
                    n_hold   = i_cfg.hold_length;
                    n_pvalid = 1'b0;
                end
            end
        end else begin
            n_pvalid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tenths  <= 1'b0;
            r_value   <= '0;
            r_dir     <= DIR_NONE;
            r_hold    <= '0;
            r_pvalid  <= 1'b0;
            r_ptenths <= 1'b0;
            r_pvalue  <= '0;
            r_pcount  <= '0;
        end else if (i_load) begin
            r_tenths  <= n_tenths;
            r_value   <= n_value;
            r_dir     <= n_dir;
            r_hold    <= n_hold;
            r_pvalid  <= n_pvalid;
            r_ptenths <= n_ptenths;
            r_pvalue  <= n_pvalue;
            r_pcount  <= n_pcount;
        end
    end

    assign o_shown.tenths_mode = r_tenths;
    assign o_shown.value       = r_value;
    assign o_shown.direction   = r_dir;

`ifndef SYNTHESIS
    hold_counts_down: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_load && !i_item.seed && r_hold != 8'd0) |=> (r_hold == $past(r_hold) - 8'd1))
        else $error("hold counter did not count down");
`endif

endmodule
`default_nettype wire

>>> hw/rtl/rate_display_stabilizer_core.sv
// Top level of the rate display stabiliser: input register, average, rounding and display stages.
`default_nettype none
// One rate word per display frame enters through i_valid/o_stall and one display word leaves
// through o_valid/i_stall for each. A word passes four register stages (input, moving
// average, rounding, display state), and a new word can be taken in every cycle while the
// output is not stalled. The rate is set by the average update, one 48 by 16 bit product
// formed as two partial products.
module rate_display_stabilizer_core (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_valid,
    output logic                   o_stall,
    input  wire logic [31:0]       i_rate,
    output logic                   o_valid,
    input  wire logic              i_stall,
    output logic [3:0]             o_high_symbol,
    output logic [3:0]             o_low_symbol,
    output logic                   o_tenths_mode,
    output logic signed [1:0]      o_roll_direction,
    input  wire logic              i_cfg_we,
    input  wire logic [2:0]        i_cfg_index,
    input  wire logic [31:0]       i_cfg_data
);
    import rds_pkg::*;

    t_cfg        r_cfg;
    logic        r_v1;
    logic        r_v2;
    logic        r_v3;
    logic        r_v4;
    logic [31:0] r_rate;
    t_filtered   r_filt;
    t_filtered   n_filt;

    logic        adv2;
    logic        adv3;
    logic        adv4;
    logic        take;
    logic        accept;

    logic [47:0] avg;
    logic        seed;
    logic [48:0] sum_t;
    logic [48:0] sum_w;
    logic [32:0] q_t;
    logic [32:0] q_w;
    logic [3:0]  cnt_t;
    logic [54:0] prod_w;
    logic [6:0]  est_w;
    t_shown      shown;
    logic [6:0]  whole_v;
    logic [3:0]  tens;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.ema_alpha      <= 16'd3277;
            r_cfg.mode_up_rate   <= 32'd1250000;
            r_cfg.mode_down_rate <= 32'd750000;
            r_cfg.band_tenths    <= 8'd15;
            r_cfg.hold_length    <= 8'd40;
            r_cfg.commit_length  <= 8'd12;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_EMA_ALPHA:      r_cfg.ema_alpha      <= i_cfg_data[15:0];
                REG_MODE_UP_RATE:   r_cfg.mode_up_rate   <= i_cfg_data;
                REG_MODE_DOWN_RATE: r_cfg.mode_down_rate <= i_cfg_data;
                REG_BAND_TENTHS:    r_cfg.band_tenths    <= i_cfg_data[7:0];
                REG_HOLD_LENGTH:    r_cfg.hold_length    <= i_cfg_data[7:0];
                REG_COMMIT_LENGTH:  r_cfg.commit_length  <= i_cfg_data[7:0];
                default: begin
                end
            endcase
        end
    end

    assign take    = r_v4 && !i_stall;
    assign adv4    = r_v3 && (!r_v4 || !i_stall);
    assign adv3    = r_v2 && (!r_v3 || adv4);
    assign adv2    = r_v1 && (!r_v2 || adv3);
    assign o_stall = r_v1 && !adv2;
    assign accept  = i_valid && !o_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            if (accept) begin
                r_v1 <= 1'b1;
            end else if (adv2) begin
                r_v1 <= 1'b0;
            end
            if (adv2) begin
                r_v2 <= 1'b1;
            end else if (adv3) begin
                r_v2 <= 1'b0;
            end
            if (adv3) begin
                r_v3 <= 1'b1;
            end else if (adv4) begin
                r_v3 <= 1'b0;
            end
            if (adv4) begin
                r_v4 <= 1'b1;
            end else if (take) begin
                r_v4 <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_rate <= i_rate;
        end
        if (adv3) begin
            r_filt <= n_filt;
        end
    end

    rds_ema u_ema (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (adv2),
        .i_rate  (r_rate),
        .i_alpha (r_cfg.ema_alpha),
        .o_avg   (avg),
        .o_seed  (seed)
    );

    // Rounding half up is done on the whole part, which gives the same quotient.
    always_comb begin
        sum_t = {1'b0, avg} + HALF_TENTHS;
        sum_w = {1'b0, avg} + HALF_WHOLE;
        q_t   = sum_t[48:16];
        q_w   = sum_w[48:16];
        cnt_t = '0;
        for (int k = 1; k <= 9; k++) begin
            cnt_t = cnt_t + 4'(q_t >= 33'(k * TENTHS_UNIT));
        end
        prod_w = 55'(q_w[26:0]) * 55'(RECIP_WHOLE);
        est_w  = prod_w[53:47];

        n_filt.seed         = seed;
        n_filt.seed_tenths  = avg < {32'(SEED_SPLIT), 16'b0};
        n_filt.up_hit       = avg >= {r_cfg.mode_up_rate, 16'b0};
        n_filt.down_hit     = avg < {r_cfg.mode_down_rate, 16'b0};
        n_filt.round_tenths = cnt_t;
        if (q_w >= 33'(WHOLE_CAP)) begin
            n_filt.round_whole = MAX_WHOLE;
        end else if (est_w < MIN_WHOLE) begin
            n_filt.round_whole = MIN_WHOLE;
        end else begin
            n_filt.round_whole = est_w;
        end
        n_filt.avg = avg;
    end

    rds_track u_track (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (adv4),
        .i_item  (r_filt),
        .i_cfg   (r_cfg),
        .o_shown (shown)
    );

    always_comb begin
        if (shown.value < MIN_WHOLE) begin
            whole_v = MIN_WHOLE;
        end else if (shown.value > MAX_WHOLE) begin
            whole_v = MAX_WHOLE;
        end else begin
            whole_v = shown.value;
        end
        tens = '0;
        for (int k = 1; k <= 9; k++) begin
            tens = tens + 4'(whole_v >= 7'(k * 10));
        end
        if (shown.tenths_mode) begin
            o_high_symbol = DOT_SYMBOL;
            o_low_symbol  = (shown.value > MAX_TENTHS) ? 4'(MAX_TENTHS) : shown.value[3:0];
        end else begin
            o_high_symbol = tens;
            o_low_symbol  = 4'(whole_v - 7'(tens) * 7'd10);
        end
    end

    assign o_valid          = r_v4;
    assign o_tenths_mode    = shown.tenths_mode;
    assign o_roll_direction = shown.direction;

`ifndef SYNTHESIS
    stall_only_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (r_v2 && r_v3 && r_v4 && i_stall))
        else $error("input stalled while the pipeline had room");
    symbols_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_low_symbol <= 4'd9 && o_high_symbol <= DOT_SYMBOL))
        else $error("display symbol out of range");
    direction_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_roll_direction != 2'sb10)
        else $error("invalid roll direction code");
    drains_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!r_v1 && !r_v2 && !r_v3 && take) |=> !o_valid)
        else $error("result word repeated after the pipeline drained");
`endif

endmodule
`default_nettype wire
